// File: rtl/sorted_key_table_assert.svh
// Assertion macros for the sorted key table RTL
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SKT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SKT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`else
`define SKT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define SKT_ASSERT(lbl, prop, msg)
`endif
`endif

// File: rtl/skt_pkg.sv
// Types, codes and defaults shared by the sorted key table modules
package skt_pkg;

    localparam int unsigned CAPACITY_DEF  = 128;
    localparam int unsigned KEY_BYTES_DEF = 8;
    localparam int unsigned KEY_W         = 64;
    localparam int unsigned IDX_W         = 7;
    localparam int unsigned CMD_W         = 3;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned COUNT_OUT_W   = 8;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_INSERT = 3'd0;
    localparam t_cmd CMD_APPEND = 3'd1;
    localparam t_cmd CMD_REMOVE = 3'd2;
    localparam t_cmd CMD_SWAP   = 3'd3;
    localparam t_cmd CMD_READ   = 3'd4;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_BADIDX = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_TAIL,
        S_REM_RD,
        S_REM_WR,
        S_SWP_RDA,
        S_SWP_RDB,
        S_SWP_WRA,
        S_SWP_WRB,
        S_READ_RD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        WS_KEY,
        WS_CARRY,
        WS_RDATA,
        WS_TMP
    } t_wr_sel;

    // controller -> datapath
    typedef struct packed {
        logic                   key_load;
        logic                   rd_en;
        logic                   wr_en;
        t_wr_sel                wr_sel;
        logic                   carry_load;
        logic                   tmp_load;
        logic                   out_load;
        t_status                out_status;
        logic [COUNT_OUT_W-1:0] out_count;
        logic                   out_key_en;
        logic                   out_digit_en;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic lt;
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/skt_dpath.sv
// Datapath: entry memory, key/carry/temp registers and the result register
module skt_dpath
    import skt_pkg::*;
#(
    parameter int unsigned CAPACITY  = CAPACITY_DEF,
    parameter int unsigned KEY_BYTES = KEY_BYTES_DEF,
    localparam int unsigned ADDR_W   = $clog2(CAPACITY)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [KEY_W-1:0]       i_key_in,
    input  t_dp_cmd                i_cmd,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  logic                   i_out_ready,
    output t_dp_stat               o_stat,
    output logic                   o_out_valid,
    output t_status                o_status,
    output logic [COUNT_OUT_W-1:0] o_count,
    output logic [KEY_W-1:0]       o_key,
    output logic                   o_has_digit
);

    logic [KEY_W-1:0] mem [CAPACITY];

    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       r_carry;
    logic [KEY_W-1:0]       r_tmp;
    logic [KEY_W-1:0]       r_rd_data;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic [KEY_W-1:0]       r_out_key;
    logic                   r_out_digit;

    logic [KEY_W-1:0] key_masked;
    logic [KEY_W-1:0] wr_data;
    logic             digit;
    logic             out_free;

    // bytes above KEY_BYTES are dropped
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            key_masked[8*b +: 8] = (b < KEY_BYTES) ? i_key_in[8*b +: 8] : 8'h00;
        end
    end

    always_comb begin
        digit = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if ((b < KEY_BYTES) && (r_key[8*b +: 8] inside {[8'h30:8'h39]})) begin
                digit = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WS_KEY:   wr_data = r_key;
            WS_CARRY: wr_data = r_carry;
            WS_RDATA: wr_data = r_rd_data;
            WS_TMP:   wr_data = r_tmp;
            default:  wr_data = r_key;
        endcase
    end

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_stat.lt       = r_key < r_rd_data;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_key <= key_masked;
        end
        if (i_cmd.carry_load) begin
            r_carry <= r_rd_data;
        end
        if (i_cmd.tmp_load) begin
            r_tmp <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_count  <= i_cmd.out_count;
            r_out_key    <= i_cmd.out_key_en ? r_rd_data : '0;
            r_out_digit  <= i_cmd.out_digit_en & digit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_key       = r_out_key;
    assign o_has_digit = r_out_digit;

endmodule

// File: rtl/skt_ctrl.sv
// Controller: command sequencing, entry count and memory addressing
module skt_ctrl
    import skt_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    localparam int unsigned ADDR_W  = $clog2(CAPACITY),
    localparam int unsigned COUNT_W = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_cmd               i_cmd,
    input  logic [IDX_W-1:0]   i_index_a,
    input  logic [IDX_W-1:0]   i_index_b,
    input  t_dp_stat           i_stat,
    output t_dp_cmd            o_cmd,
    output logic [ADDR_W-1:0]  o_rd_addr,
    output logic [ADDR_W-1:0]  o_wr_addr,
    output logic [COUNT_W-1:0] o_count
);

    localparam int unsigned CW = COUNT_W + IDX_W;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    t_status             r_status, n_status;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [ADDR_W-1:0]   r_idx_b, n_idx_b;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_found, n_found;

    logic [CW-1:0]          a_ext;
    logic [CW-1:0]          b_ext;
    logic [CW-1:0]          idx_ext;
    logic [CW-1:0]          cnt_ext;
    logic [COUNT_W+7:0]     cnt_wide;
    logic                   full;
    logic                   a_bad;
    logic                   b_bad;

    assign a_ext    = CW'(i_index_a);
    assign b_ext    = CW'(i_index_b);
    assign idx_ext  = CW'(r_idx);
    assign cnt_ext  = CW'(r_count);
    assign cnt_wide = {8'b0, r_count};
    assign full     = r_count >= COUNT_W'(CAPACITY);
    assign a_bad    = a_ext >= cnt_ext;
    assign b_bad    = b_ext >= cnt_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_idx_b  <= n_idx_b;
        r_found  <= n_found;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_status   = r_status;
        n_idx      = r_idx;
        n_idx_b    = r_idx_b;
        n_count    = r_count;
        n_found    = r_found;
        o_cmd      = '0;
        o_rd_addr  = r_idx;
        o_wr_addr  = r_idx;
        o_in_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.key_load = 1'b1;
                    n_cmd    = i_cmd;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_idx    = a_ext[ADDR_W-1:0];
                    n_idx_b  = b_ext[ADDR_W-1:0];
                    n_state  = S_DONE;
                    case (i_cmd)
                        CMD_INSERT, CMD_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if ((i_cmd == CMD_INSERT) && (r_count != '0)) begin
                                n_idx   = '0;
                                n_state = S_INS_RD;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        CMD_REMOVE: begin
                            if (a_bad) begin
                                n_status = ST_BADIDX;
                            end else if ((a_ext + CW'(1)) == cnt_ext) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                n_state = S_REM_RD;
                            end
                        end
                        CMD_SWAP: begin
                            if (a_bad || b_bad) begin
                                n_status = ST_BADIDX;
                            end else begin
                                n_state = S_SWP_RDA;
                            end
                        end
                        CMD_READ: begin
                            if (a_bad) begin
                                n_status = ST_BADIDX;
                            end else begin
                                n_state = S_READ_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_INS_WR;
            end

            // once the slot is found every later entry moves up by one via the carry
            S_INS_WR: begin
                if (r_found) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_sel     = WS_CARRY;
                    o_cmd.carry_load = 1'b1;
                end else if (i_stat.lt) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_sel     = WS_KEY;
                    o_cmd.carry_load = 1'b1;
                    n_found          = 1'b1;
                end
                n_idx = ADDR_W'(r_idx + 1'b1);
                if ((idx_ext + CW'(1)) == cnt_ext) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_INS_RD;
                end
            end

            S_TAIL: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = r_found ? WS_CARRY : WS_KEY;
                o_wr_addr    = r_count[ADDR_W-1:0];
                n_count      = r_count + 1'b1;
                n_state      = S_DONE;
            end

            S_REM_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = ADDR_W'(r_idx + 1'b1);
                n_state     = S_REM_WR;
            end

            S_REM_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RDATA;
                n_idx        = ADDR_W'(r_idx + 1'b1);
                if ((idx_ext + CW'(2)) == cnt_ext) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_REM_RD;
                end
            end

            S_SWP_RDA: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SWP_RDB;
            end

            S_SWP_RDB: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.tmp_load = 1'b1;
                o_rd_addr      = r_idx_b;
                n_state        = S_SWP_WRA;
            end

            S_SWP_WRA: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RDATA;
                n_state      = S_SWP_WRB;
            end

            S_SWP_WRB: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_TMP;
                o_wr_addr    = r_idx_b;
                n_state      = S_DONE;
            end

            S_READ_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_DONE;
            end

            // read data stays in the datapath until the result is loaded
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_status   = r_status;
                    o_cmd.out_count    = cnt_wide[7:0];
                    o_cmd.out_key_en   = (r_cmd == CMD_READ) && (r_status == ST_OK);
                    o_cmd.out_digit_en = (r_cmd == CMD_INSERT) && (r_status == ST_OK);
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_count = r_count;

endmodule

// File: rtl/sorted_key_table.sv
// Sorted key table: up to CAPACITY keys of up to KEY_BYTES bytes, packed big-endian so that
// unsigned order is string order, held in a single-port-read, single-port-write memory with a
// registered read. One command is in work at a time; the result register frees the input side
// as soon as a result is loaded. Sorted insert and remove move entries one at a time, each a read
// and then a write through the one memory read port, so their time grows with the entries moved.
// The memory needs no clearing after reset: only positions below the entry count are ever read.
`include "sorted_key_table_assert.svh"

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int unsigned CAPACITY  = CAPACITY_DEF,
    parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // key_in[63:0], index_a[70:64], index_b[77:71], zero
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // status[1:0], count_out[9:2], key_out[73:10],
                                        // has_digit[74], zero
);

    localparam int unsigned ADDR_W  = $clog2(CAPACITY);
    localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

    t_dp_cmd                dp_cmd;
    t_dp_stat               dp_stat;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_W-1:0]     ctl_count;
    t_status                out_status;
    logic [COUNT_OUT_W-1:0] out_count;
    logic [KEY_W-1:0]       out_key;
    logic                   out_digit;

    skt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_index_a  (s_axis_tdata[70:64]),
        .i_index_b  (s_axis_tdata[77:71]),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_count    (ctl_count)
    );

    skt_dpath #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_in    (s_axis_tdata[63:0]),
        .i_cmd       (dp_cmd),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .i_out_ready (m_axis_tready),
        .o_stat      (dp_stat),
        .o_out_valid (m_axis_tvalid),
        .o_status    (out_status),
        .o_count     (out_count),
        .o_key       (out_key),
        .o_has_digit (out_digit)
    );

    assign m_axis_tdata = {5'b0, out_digit, out_key, out_count, out_status};

    // writes land inside the stored range or at the tail slot
    `SKT_ASSERT(a_wr_in_range, dp_cmd.wr_en |-> (COUNT_W'(wr_addr) <= ctl_count), "write past tail")
    // a pending result is never overwritten
    `SKT_ASSERT(a_no_overwrite, dp_cmd.out_load |-> dp_stat.out_free, "result overwritten")
    // rejected inserts carry neither a key nor a digit flag
    `SKT_ASSERT(a_full_clean, (m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL)) |-> (m_axis_tdata[74:10] == '0), "full result not clean")

endmodule
